// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a must imply b on the same clock edge, outside reset
`define BBS_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// expression must never be true, outside reset
`define BBS_ASSERT_NEVER(lbl, clk, rst_n, e) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(e)) \
        else $error("assertion failed");

`endif

// ===== rtl/bbs_pkg.sv =====
// types, constants and command/status structs of the box blur block
package bbs_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int WCFG_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int SUM_W     = 12;
    localparam int N_W       = 4;
    localparam int REM_W     = SUM_W + 1;
    localparam int RCP_W     = 18;
    localparam int RCP_SH    = 18;
    localparam int PROD_W    = REM_W + RCP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        SEL_A = 2'd0,
        SEL_B = 2'd1,
        SEL_D = 2'd2
    } sum_sel_t;

    typedef enum logic [1:0] {
        RA_COL = 2'd0,
        RA_DM1 = 2'd1,
        RA_D0  = 2'd2,
        RA_DP1 = 2'd3
    } raddr_sel_t;

    typedef struct packed {
        logic       cap_pix;
        logic       push;
        raddr_sel_t raddr_sel;
        logic       cap_en;
        logic [1:0] cap_slot;
        logic       sum_en;
        sum_sel_t   sum_sel;
        logic       div_en;
        logic       out_load;
        logic       out_last;
        logic       out_done;
        logic       drain_adv;
    } cmd_t;

    typedef struct packed {
        logic frame_full;
        logic has_a;
        logic has_b;
        logic drain_done;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/bbs_ifs.sv =====
// stream and configuration channel interfaces
interface bbs_pix_if;
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [bbs_pkg::CH_W-1:0] in_red;
    logic [bbs_pkg::CH_W-1:0] in_green;
    logic [bbs_pkg::CH_W-1:0] in_blue;
    modport source (output valid, operation, in_red, in_green, in_blue, input ready);
    modport sink (input valid, operation, in_red, in_green, in_blue, output ready);
endinterface

interface bbs_res_if;
    logic                   valid;
    logic                   ready;
    logic [bbs_pkg::CH_W-1:0] out_red;
    logic [bbs_pkg::CH_W-1:0] out_green;
    logic [bbs_pkg::CH_W-1:0] out_blue;
    logic                   last_of_step;
    logic                   frame_done;
    modport source (output valid, out_red, out_green, out_blue, last_of_step, frame_done,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, last_of_step, frame_done,
                  output ready);
endinterface

interface bbs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bbs_pkg::CFG_IDX_W-1:0] index;
    logic [bbs_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bbs_ram.sv =====
// generic single-write, single-read ram with registered read data
module bbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bbs_datapath.sv =====
// datapath: config, counters, line buffers, window, summer, reciprocal divide, output register
module bbs_datapath import bbs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              st,
    input  logic [PIX_W-1:0]     in_pixel,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [CH_W-1:0]      out_red,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_blue,
    output logic                 out_last,
    output logic                 out_done
);

    logic [WCFG_W-1:0] image_width_reg;
    logic [ROW_W-1:0]  image_height_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  drain_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  win_reg [3][3];
    logic [PIX_W-1:0]  dr_reg [3][2];
    logic              c1_reg, c2_reg, r2_reg;
    logic [SUM_W-1:0]  s_reg [3];
    logic [N_W-1:0]    n_reg;
    logic [CH_W-1:0]   q_reg [3];
    logic              out_valid_reg;
    logic [CH_W-1:0]   ored_reg, ogreen_reg, oblue_reg;
    logic              olast_reg, odone_reg;

    logic [COL_W-1:0]  wm1;
    logic [ROW_W-1:0]  h_eff;
    logic              edge_hit;
    logic [COL_W-1:0]  raddr;
    logic [PIX_W-1:0]  old_rd, new_rd;
    logic [PIX_W-1:0]  m [3][3];
    logic [2:0]        cv, rv;
    logic [SUM_W-1:0]  s_next [3];
    logic [N_W-1:0]    n_next;
    logic [REM_W-1:0]  num [3];
    logic [RCP_W-1:0]  rcp;
    logic [PROD_W-1:0] prod [3];

    // effective frame size
    always_comb
    begin
        if (image_width_reg == '0)
            wm1 = '0;
        else if (32'(image_width_reg) > MAX_WIDTH)
            wm1 = COL_W'(MAX_WIDTH - 1);
        else
            wm1 = COL_W'(image_width_reg - WCFG_W'(1));
        h_eff = (image_height_reg == '0) ? ROW_W'(1) : image_height_reg;
    end

    assign edge_hit = col_reg >= wm1;

    // status to the controller
    always_comb
    begin
        st.frame_full = row_reg >= h_eff;
        st.has_a      = (row_reg != '0) && (col_reg != '0);
        st.has_b      = edge_hit && (row_reg != '0);
        st.drain_done = drain_reg >= wm1;
        st.out_free   = !out_valid_reg || out_ready;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WCFG_W'(640);
            image_height_reg <= ROW_W'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  image_width_reg  <= cfg_data[WCFG_W-1:0];
                CFG_HEIGHT: image_height_reg <= cfg_data[ROW_W-1:0];
                default:    ;
            endcase
        end
    end

    // position counters and column flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
            c1_reg    <= 1'b0;
            c2_reg    <= 1'b0;
            r2_reg    <= 1'b0;
        end
        else if (cmd.push)
        begin
            c1_reg <= col_reg != '0;
            c2_reg <= col_reg >= COL_W'(2);
            r2_reg <= row_reg >= ROW_W'(2);
            if (edge_hit)
            begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
        else if (cmd.drain_adv)
        begin
            if (st.drain_done)
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                drain_reg <= '0;
            end
            else
            begin
                drain_reg <= drain_reg + COL_W'(1);
            end
        end
    end

    // line buffer read address
    always_comb
    begin
        case (cmd.raddr_sel)
            RA_COL: raddr = col_reg;
            RA_DM1: raddr = (drain_reg == '0) ? '0 : drain_reg - COL_W'(1);
            RA_D0:  raddr = drain_reg;
            RA_DP1: raddr = (drain_reg == COL_W'(MAX_WIDTH - 1)) ? drain_reg
                                                                 : drain_reg + COL_W'(1);
            default: raddr = col_reg;
        endcase
    end

    bbs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (col_reg),
        .wdata (new_rd),
        .raddr (raddr),
        .rdata (old_rd)
    );

    bbs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (col_reg),
        .wdata (pix_reg),
        .raddr (raddr),
        .rdata (new_rd)
    );

    // pixel capture, window shift and drain columns
    always_ff @(posedge clk)
    begin
        if (cmd.cap_pix)
            pix_reg <= in_pixel;
        if (cmd.push)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2][0] <= old_rd;
            win_reg[2][1] <= new_rd;
            win_reg[2][2] <= pix_reg;
        end
        if (cmd.cap_en)
        begin
            dr_reg[cmd.cap_slot][0] <= old_rd;
            dr_reg[cmd.cap_slot][1] <= new_rd;
        end
    end

    // neighborhood selection and masks
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                m[k][j] = win_reg[k][j];
        cv = {1'b1, 1'b1, c2_reg};
        rv = {1'b1, 1'b1, r2_reg};
        case (cmd.sum_sel)
            SEL_A: ;
            SEL_B:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    m[0][j] = win_reg[1][j];
                    m[1][j] = win_reg[2][j];
                    m[2][j] = '0;
                end
                cv = {1'b0, 1'b1, c1_reg};
            end
            SEL_D:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    m[k][0] = dr_reg[k][0];
                    m[k][1] = dr_reg[k][1];
                    m[k][2] = '0;
                end
                cv = {!st.drain_done, 1'b1, drain_reg != '0};
                rv = {1'b0, 1'b1, h_eff >= ROW_W'(2)};
            end
            default: ;
        endcase
    end

    // per-channel sums and neighbor count
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            s_next[ch] = '0;
        n_next = '0;
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                if (cv[k] && rv[j])
                begin
                    n_next = n_next + N_W'(1);
                    for (int ch = 0; ch < 3; ch++)
                        s_next[ch] = s_next[ch]
                                   + SUM_W'(m[k][j][(2 - ch) * CH_W +: CH_W]);
                end
        if (n_next == '0)
            n_next = N_W'(1);
    end

    // reciprocal of 2n scaled by 2^18, rounded up; exact for numerators below 2^13
    // counts 5, 7 and 8 never occur, count 1 takes the default arm
    always_comb
    begin
        case (n_reg)
            N_W'(2): rcp = RCP_W'(65536);
            N_W'(3): rcp = RCP_W'(43691);
            N_W'(4): rcp = RCP_W'(32768);
            N_W'(6): rcp = RCP_W'(21846);
            N_W'(9): rcp = RCP_W'(14564);
            default: rcp = RCP_W'(131072);
        endcase
        for (int ch = 0; ch < 3; ch++)
        begin
            num[ch]  = {s_reg[ch], 1'b0} + REM_W'(n_reg);
            prod[ch] = PROD_W'(num[ch]) * PROD_W'(rcp);
        end
    end

    // summer register and rounded quotient register
    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            s_reg <= s_next;
            n_reg <= n_next;
        end
        if (cmd.div_en)
        begin
            for (int ch = 0; ch < 3; ch++)
                q_reg[ch] <= prod[ch][RCP_SH +: CH_W];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ored_reg   <= q_reg[0];
            ogreen_reg <= q_reg[1];
            oblue_reg  <= q_reg[2];
            olast_reg  <= cmd.out_last;
            odone_reg  <= cmd.out_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = ored_reg;
    assign out_green = ogreen_reg;
    assign out_blue  = oblue_reg;
    assign out_last  = olast_reg;
    assign out_done  = odone_reg;

endmodule

// ===== rtl/bbs_ctrl.sv =====
// controller state machine: sequences push, drain reads, sums, divide and output
module bbs_ctrl import bbs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_op,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PUSH  = 9'b000000010,
        S_DR0   = 9'b000000100,
        S_DR1   = 9'b000001000,
        S_DR2   = 9'b000010000,
        S_DR3   = 9'b000100000,
        S_SUM   = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t   state_reg, state_next;
    sum_sel_t sel_reg, sel_next;
    logic     has_b_reg, has_b_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_A;
            has_b_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            has_b_reg <= has_b_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        has_b_next = has_b_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.raddr_sel = RA_COL;
        cmd.sum_sel   = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_PUSH)
                    begin
                        if (!st.frame_full)
                        begin
                            cmd.cap_pix = 1'b1;
                            state_next  = S_PUSH;
                        end
                    end
                    else if (st.frame_full)
                    begin
                        state_next = S_DR0;
                    end
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                has_b_next = st.has_b;
                if (st.has_a)
                begin
                    sel_next   = SEL_A;
                    state_next = S_SUM;
                end
                else if (st.has_b)
                begin
                    sel_next   = SEL_B;
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DR0:
            begin
                cmd.raddr_sel = RA_DM1;
                state_next    = S_DR1;
            end
            S_DR1:
            begin
                cmd.raddr_sel = RA_D0;
                cmd.cap_en    = 1'b1;
                cmd.cap_slot  = 2'd0;
                state_next    = S_DR2;
            end
            S_DR2:
            begin
                cmd.raddr_sel = RA_DP1;
                cmd.cap_en    = 1'b1;
                cmd.cap_slot  = 2'd1;
                state_next    = S_DR3;
            end
            S_DR3:
            begin
                cmd.cap_en   = 1'b1;
                cmd.cap_slot = 2'd2;
                sel_next     = SEL_D;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_en = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_last  = (sel_reg != SEL_A) || !has_b_reg;
                    cmd.out_done  = (sel_reg == SEL_D) && st.drain_done;
                    cmd.drain_adv = sel_reg == SEL_D;
                    if ((sel_reg == SEL_A) && has_b_reg)
                    begin
                        sel_next   = SEL_B;
                        state_next = S_SUM;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/box_blur_3x3_stream.sv =====
// top level of the streaming 3x3 box blur
//
//  channel | dir | payload
//  --------+-----+-------------------------------------------------------
//  pix     | in  | operation, in_red, in_green, in_blue
//  res     | out | out_red, out_green, out_blue, last_of_step, frame_done
//  cfg     | in  | index (0 width, 1 height), data
//
// a push is accepted, then written; each result passes the sum, reciprocal multiply and load steps
// a drain is accepted and reads the line buffers before its result; an ignored item is only accepted
// reset leaves the line buffers unwritten, no clearing pass; size regs 640 x 480
// a result waits in the output register; the next item is taken meanwhile and
// the block stalls only when a new result finds that register still full
`include "assert_macros.svh"

module box_blur_3x3_stream import bbs_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    bbs_pix_if.sink   pix,
    bbs_res_if.source res,
    bbs_cfg_if.sink   cfg
);

    cmd_t    cmd;
    status_t st;
    logic    in_ready;

    // configuration is always taken
    assign cfg.ready = 1'b1;
    assign pix.ready = in_ready;

    bbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_op    (pix.operation),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    bbs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_pixel  ({pix.in_red, pix.in_green, pix.in_blue}),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_ready (res.ready),
        .out_valid (res.valid),
        .out_red   (res.out_red),
        .out_green (res.out_green),
        .out_blue  (res.out_blue),
        .out_last  (res.last_of_step),
        .out_done  (res.frame_done)
    );

    // checks
    `BBS_ASSERT_NEVER(a_no_write_on_accept, clk, rst_n, cmd.push && in_ready)
    `BBS_ASSERT_IMPL(a_load_into_free, clk, rst_n, cmd.out_load, st.out_free)
    `BBS_ASSERT_IMPL(a_done_is_last, clk, rst_n, res.valid && res.frame_done,
                     res.last_of_step)

endmodule

// ===== tb/box_blur_3x3_stream_tb.sv =====
// self-checking testbench of the streaming 3x3 box blur
module box_blur_3x3_stream_tb;
    import bbs_pkg::*;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;  // [column][row]

    typedef struct packed {
        pixel_t rgb;
        logic   last_of_step;
        logic   frame_done;
    } blur_out_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 op;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] val;
        pixel_t               rgb;
        logic                 has_exp;
        pixel_t               exp_rgb;
    } dir_row_t;

    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 500;

    // directed rows: size extremes, ignored items, one-pixel frames, small frames
    localparam dir_row_t DIR_TAB [23] = '{
        '{ROW_CFG,  OP_PUSH,  CFG_WIDTH,  16'd0,  24'h0,      1'b0, 24'h0},
        '{ROW_CFG,  OP_PUSH,  CFG_HEIGHT, 16'd0,  24'h0,      1'b0, 24'h0},
        '{ROW_ITEM, OP_DRAIN, CFG_WIDTH,  16'd0,  24'h0,      1'b0, 24'h0},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'hff0080, 1'b0, 24'h0},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'h123456, 1'b0, 24'h0},
        '{ROW_ITEM, OP_DRAIN, CFG_WIDTH,  16'd0,  24'h0,      1'b1, 24'hff0080},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'h000000, 1'b0, 24'h0},
        '{ROW_ITEM, OP_DRAIN, CFG_WIDTH,  16'd0,  24'hffffff, 1'b1, 24'h000000},
        '{ROW_CFG,  OP_PUSH,  CFG_WIDTH,  16'd2,  24'h0,      1'b0, 24'h0},
        '{ROW_CFG,  OP_PUSH,  CFG_HEIGHT, 16'd2,  24'h0,      1'b0, 24'h0},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'hffffff, 1'b0, 24'h0},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'h000000, 1'b0, 24'h0},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'h000000, 1'b0, 24'h0},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'hffffff, 1'b0, 24'h0},
        '{ROW_ITEM, OP_DRAIN, CFG_WIDTH,  16'd0,  24'h0,      1'b0, 24'h0},
        '{ROW_ITEM, OP_DRAIN, CFG_WIDTH,  16'd0,  24'h0,      1'b0, 24'h0},
        '{ROW_CFG,  OP_PUSH,  CFG_WIDTH,  16'd3,  24'h0,      1'b0, 24'h0},
        '{ROW_CFG,  OP_PUSH,  CFG_HEIGHT, 16'd1,  24'h0,      1'b0, 24'h0},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'hff00ff, 1'b0, 24'h0},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'h00ff00, 1'b0, 24'h0},
        '{ROW_ITEM, OP_PUSH,  CFG_WIDTH,  16'd0,  24'h808080, 1'b0, 24'h0},
        '{ROW_ITEM, OP_DRAIN, CFG_WIDTH,  16'd0,  24'h0,      1'b0, 24'h0},
        '{ROW_ITEM, OP_DRAIN, CFG_WIDTH,  16'd0,  24'h0,      1'b0, 24'h0}
    };

    logic clk;
    logic rst_n;

    bbs_pix_if pix_ch ();
    bbs_res_if res_ch ();
    bbs_cfg_if cfg_ch ();

    box_blur_3x3_stream u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // blur model state
    pixel_t               older_line [MAX_WIDTH];
    pixel_t               newer_line [MAX_WIDTH];
    window_t              win;
    logic [WCFG_W-1:0]    width_reg;
    logic [ROW_W-1:0]     height_reg;
    int unsigned          push_col;
    int unsigned          push_row;
    int unsigned          drain_col;

    blur_out_t blurred_q [$];
    int        fail_count;
    int        idle_cycles;
    bit        no_idle;
    bit        hold_req;
    int        hold_left;
    int        stall_left;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return 0;
        else if (sel < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic int unsigned clamp_col(int unsigned i);
        return (i >= MAX_WIDTH) ? MAX_WIDTH - 1 : i;
    endfunction

    // rounded-half-up mean of the valid part of a window
    function automatic pixel_t box_mean(window_t px, logic [2:0] cv, logic [2:0] rv);
        int unsigned s_r, s_g, s_b, n;
        pixel_t      m;
        s_r = 0;
        s_g = 0;
        s_b = 0;
        n   = 0;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                if (cv[c] && rv[r])
                begin
                    s_r += px[c][r][23:16];
                    s_g += px[c][r][15:8];
                    s_b += px[c][r][7:0];
                    n++;
                end
        if (n == 0)
            n = 1;
        m[23:16] = 8'((2 * s_r + n) / (2 * n));
        m[15:8]  = 8'((2 * s_g + n) / (2 * n));
        m[7:0]   = 8'((2 * s_b + n) / (2 * n));
        return m;
    endfunction

    function automatic void add_blurred(pixel_t rgb, logic done);
        blur_out_t o;
        o.rgb          = rgb;
        o.last_of_step = 1'b0;
        o.frame_done   = done;
        blurred_q.push_back(o);
    endfunction

    // advance the blur model by one accepted item, queueing the pixels it yields
    function automatic void blur_step(logic op, pixel_t rgb);
        int unsigned w, h, c, r, d, k, idx;
        logic        edge_col, done;
        logic [2:0]  cv, rv;
        window_t     px;
        int          before_n;
        w = eff_width();
        h = eff_height();
        before_n = blurred_q.size();
        if (op == OP_PUSH)
        begin
            c = clamp_col(push_col);
            r = push_row;
            edge_col = (c >= w - 1);
            if (r >= h)
                return;
            win[0] = win[1];
            win[1] = win[2];
            win[2][0] = older_line[c];
            win[2][1] = newer_line[c];
            win[2][2] = rgb;
            older_line[c] = newer_line[c];
            newer_line[c] = rgb;
            if (r >= 1)
            begin
                rv = {1'b1, 1'b1, r >= 2};
                if (c >= 1)
                    add_blurred(box_mean(win, {1'b1, 1'b1, c >= 2}, rv), 1'b0);
                if (edge_col)
                begin
                    px = '0;
                    px[0] = win[1];
                    px[1] = win[2];
                    add_blurred(box_mean(px, {1'b0, 1'b1, c >= 1}, rv), 1'b0);
                end
            end
            if (edge_col)
            begin
                push_col = 0;
                push_row = r + 1;
            end
            else
                push_col = c + 1;
        end
        else
        begin
            d = clamp_col(drain_col);
            done = (d >= w - 1);
            if (push_row < h)
                return;
            cv = {!done, 1'b1, d >= 1};
            rv = {1'b0, 1'b1, h >= 2};
            px = '0;
            for (k = 0; k < 3; k++)
            begin
                idx = clamp_col(d + k - (cv[0] ? 1 : 0));
                px[k][0] = older_line[idx];
                px[k][1] = newer_line[idx];
            end
            // column d belongs in the middle slot at the left edge
            if (!cv[0])
            begin
                px[2] = px[1];
                px[1] = px[0];
                px[0] = '0;
            end
            add_blurred(box_mean(px, cv, rv), done);
            if (done)
            begin
                push_col  = 0;
                push_row  = 0;
                drain_col = 0;
            end
            else
                drain_col = d + 1;
        end
        if (blurred_q.size() > before_n)
            blurred_q[blurred_q.size() - 1].last_of_step = 1'b1;
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_item(logic op, pixel_t rgb);
        int g;
        @(negedge clk);
        pix_ch.valid     = 1'b1;
        pix_ch.operation = op;
        pix_ch.in_red    = rgb[23:16];
        pix_ch.in_green  = rgb[15:8];
        pix_ch.in_blue   = rgb[7:0];
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        blur_step(op, rgb);
        g = no_idle ? 0 : gap_len();
        repeat (g)
        begin
            @(negedge clk);
            pix_ch.valid = 1'b0;
        end
    endtask

    // withdraw the offered item, then wait for every expected result
    task automatic wait_drained();
        @(negedge clk);
        pix_ch.valid = 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        wait_drained();
        @(negedge clk);
        pix_ch.valid = 1'b0;
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == CFG_WIDTH)
            width_reg = val[WCFG_W-1:0];
        else
            height_reg = val;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // one whole frame with random content and a little noise
    task automatic run_frame(int unsigned w, int unsigned h, bit pause_mid);
        int unsigned n;
        write_reg(CFG_WIDTH, CFG_DAT_W'(w));
        write_reg(CFG_HEIGHT, CFG_DAT_W'(h));
        n = 0;
        for (int unsigned i = 0; i < w * h; i++)
        begin
            // early drains are ignored
            if ($urandom_range(0, 24) == 0)
                send_item(OP_DRAIN, 24'($urandom));
            send_item(OP_PUSH, 24'($urandom));
            if (pause_mid && i == (w * h) / 2)
                wait_drained();
        end
        for (int unsigned i = 0; i < w; i++)
        begin
            // late pushes are ignored
            if ($urandom_range(0, 24) == 0)
                send_item(OP_PUSH, 24'($urandom));
            send_item(OP_DRAIN, 24'($urandom));
        end
    endtask

    // result side: random stalls and one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
        end
    end

    // result checker
    always @(posedge clk)
    begin
        blur_out_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (blurred_q.size() == 0)
            begin
                $error("unexpected output pixel %h", {res_ch.out_red, res_ch.out_green,
                       res_ch.out_blue});
                fail_count++;
            end
            else
            begin
                e = blurred_q.pop_front();
                if (res_ch.out_red !== e.rgb[23:16])
                begin
                    $error("out_red expected %h actual %h", e.rgb[23:16], res_ch.out_red);
                    fail_count++;
                end
                if (res_ch.out_green !== e.rgb[15:8])
                begin
                    $error("out_green expected %h actual %h", e.rgb[15:8], res_ch.out_green);
                    fail_count++;
                end
                if (res_ch.out_blue !== e.rgb[7:0])
                begin
                    $error("out_blue expected %h actual %h", e.rgb[7:0], res_ch.out_blue);
                    fail_count++;
                end
                if (res_ch.last_of_step !== e.last_of_step)
                begin
                    $error("last_of_step expected %b actual %b", e.last_of_step,
                           res_ch.last_of_step);
                    fail_count++;
                end
                if (res_ch.frame_done !== e.frame_done)
                begin
                    $error("frame_done expected %b actual %b", e.frame_done,
                           res_ch.frame_done);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("box_blur_3x3_stream test failed");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        int unsigned items, w, h;
        pix_ch.valid     = 1'b0;
        pix_ch.operation = OP_PUSH;
        pix_ch.in_red    = '0;
        pix_ch.in_green  = '0;
        pix_ch.in_blue   = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_WIDTH;
        cfg_ch.data      = '0;
        res_ch.ready     = 1'b0;
        fail_count  = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        hold_left   = 0;
        stall_left  = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        win        = '0;
        width_reg  = 12'd640;
        height_reg = 16'd480;
        push_col   = 0;
        push_row   = 0;
        drain_col  = 0;

        rst_n = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (DIR_TAB[i])
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
                write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
            else
            begin
                send_item(DIR_TAB[i].op, DIR_TAB[i].rgb);
                if (DIR_TAB[i].has_exp)
                    blurred_q[blurred_q.size() - 1].rgb = DIR_TAB[i].exp_rgb;
            end
        end

        // oversized width keeps the row open; narrowing the width closes it
        write_reg(CFG_WIDTH, 16'd4095);
        write_reg(CFG_HEIGHT, 16'd1);
        for (int i = 0; i < 16; i++)
            send_item(OP_PUSH, 24'($urandom));
        write_reg(CFG_WIDTH, 16'd17);
        send_item(OP_PUSH, 24'($urandom));
        for (int i = 0; i < 17; i++)
            send_item(OP_DRAIN, 24'($urandom));

        // tallest height, cut short by shrinking the height between rows
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'hffff);
        for (int i = 0; i < 9; i++)
            send_item(OP_PUSH, 24'($urandom));
        write_reg(CFG_HEIGHT, 16'd2);
        for (int i = 0; i < 3; i++)
            send_item(OP_DRAIN, 24'($urandom));

        // long hold-off on the result side while items keep coming
        hold_req = 1'b1;
        run_frame(12, 6, 1'b0);

        // random frames, mostly small
        items = 0;
        while (items < 800)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 15) == 0)
            begin
                w = $urandom_range(20, 60);
                h = $urandom_range(1, 3);
            end
            else
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
            end
            run_frame(w, h, $urandom_range(0, 9) == 0);
            items += w * h + w;
        end
        no_idle = 1'b0;

        @(negedge clk);
        pix_ch.valid = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && blurred_q.size() == 0)
            $display("box_blur_3x3_stream test passed");
        else
            $display("box_blur_3x3_stream test failed");
        $finish;
    end

endmodule
